// File: design/dbe_pkg.sv
// Shared types and constants for the double-ended queue engine.
`timescale 1ns / 1ps

package dbe_pkg;

   // Default geometry of the entry store.
   localparam int DEFAULT_DEPTH       = 16;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   // Operation codes carried by each input item; codes six and seven do nothing.
   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_CONTAINS   = 3'd4,
      FUNC_REMOVE     = 3'd5
   } func_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SHIFT,
      ST_REF_FRONT,
      ST_REF_BACK,
      ST_REF_CAP,
      ST_DONE
   } state_type;

   // One datapath command per cycle.
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_PUSH_FRONT,
      CMD_PUSH_BACK,
      CMD_POP_FRONT,
      CMD_POP_BACK,
      CMD_FAIL_FULL,
      CMD_FAIL_EMPTY,
      CMD_FAIL_MISS,
      CMD_SCAN,
      CMD_SHIFT,
      CMD_SHRINK,
      CMD_RD_FRONT,
      CMD_RD_BACK,
      CMD_CAP_BACK,
      CMD_OUTPUT
   } cmd_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      func_type op;
      logic     is_full;
      logic     is_empty;
      logic     scan_hit;
      logic     sweep_done;
      logic     out_free;
   } dp_stat_type;

endpackage

// File: design/dbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dbe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/dbe_datapath.sv
// Datapath of the queue engine: ring pointers, entry store, scan logic and result register.
`timescale 1ns / 1ps

module dbe_datapath #(
   parameter int DEPTH       = dbe_pkg::DEFAULT_DEPTH,
   parameter int VALUE_WIDTH = dbe_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dbe_pkg::cmd_type               cmd,
   output dbe_pkg::dp_stat_type           stat,
   input  logic [2:0]                     req_func,
   input  logic [VALUE_WIDTH-1:0]         req_item_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_found,
   output logic                           rsp_is_empty,
   output logic [$clog2(DEPTH+1)-1:0]     rsp_count,
   output logic [VALUE_WIDTH-1:0]         rsp_front_value,
   output logic [VALUE_WIDTH-1:0]         rsp_back_value
);

   import dbe_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Ring position of an offset counted from the front.
   function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] head,
                                               input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW + 1)'(head) + (CW + 1)'(off);
      if (sum >= (CW + 1)'(DEPTH)) begin
         sum = sum - (CW + 1)'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   func_type         op_ff, op_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [IW-1:0]    head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [VALUE_WIDTH-1:0] front_ff, front_in;
   logic [VALUE_WIDTH-1:0] back_ff, back_in;
   logic [CW-1:0]    off_ff, off_in;
   logic [CW-1:0]    cmp_off_ff, cmp_off_in;
   logic             pend_ff, pend_in;
   logic             found_ff, found_in;
   status_type       status_ff, status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff, rsp_found_in;
   logic             rsp_is_empty_ff, rsp_is_empty_in;
   logic [CW-1:0]    rsp_count_ff, rsp_count_in;
   logic [VALUE_WIDTH-1:0] rsp_front_ff, rsp_front_in;
   logic [VALUE_WIDTH-1:0] rsp_back_ff, rsp_back_in;

   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic                   rd_en;
   logic [IW-1:0]          rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;

   logic             is_empty;
   logic             hit;
   logic             more;
   logic [IW-1:0]    head_dec;
   logic [IW-1:0]    head_inc;

   dbe_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Flags shared by several commands.
   assign is_empty = (count_ff == '0);
   assign hit      = pend_ff && (rd_data == val_ff);
   assign more     = (off_ff < count_ff);
   assign head_dec = (head_ff == '0) ? IW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == IW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // Status toward the controller.
   always_comb begin
      stat.op         = op_ff;
      stat.is_full    = (count_ff == CW'(DEPTH));
      stat.is_empty   = is_empty;
      stat.scan_hit   = hit;
      stat.sweep_done = !pend_ff && !more;
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Command decode and next-state values.
   always_comb begin
      op_in        = op_ff;
      val_in       = val_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      off_in       = off_ff;
      cmp_off_in   = cmp_off_ff;
      pend_in      = pend_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_is_empty_in = rsp_is_empty_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_front_in    = rsp_front_ff;
      rsp_back_in     = rsp_back_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = val_ff;
      rd_en   = 1'b0;
      rd_addr = '0;

      case (cmd)
         CMD_LOAD: begin
            op_in     = func_type'(req_func);
            val_in    = req_item_value;
            off_in    = '0;
            pend_in   = 1'b0;
            found_in  = 1'b0;
            status_in = STATUS_OK;
         end
         CMD_PUSH_FRONT: begin
            head_in  = head_dec;
            wr_en    = 1'b1;
            wr_addr  = head_dec;
            count_in = count_ff + 1'b1;
            front_in = val_ff;
            if (is_empty) begin
               back_in = val_ff;
            end
         end
         CMD_PUSH_BACK: begin
            wr_en    = 1'b1;
            wr_addr  = ring_pos(head_ff, count_ff);
            count_in = count_ff + 1'b1;
            back_in  = val_ff;
            if (is_empty) begin
               front_in = val_ff;
            end
         end
         CMD_POP_FRONT: begin
            head_in  = head_inc;
            count_in = count_ff - 1'b1;
         end
         CMD_POP_BACK, CMD_SHRINK: begin
            count_in = count_ff - 1'b1;
         end
         CMD_FAIL_FULL: begin
            status_in = STATUS_FULL;
         end
         CMD_FAIL_EMPTY: begin
            status_in = STATUS_EMPTY;
         end
         CMD_FAIL_MISS: begin
            status_in = STATUS_NOT_FOUND;
         end
         CMD_SCAN: begin
            // Compare the entry read last cycle while the next one is fetched.
            if (hit) begin
               found_in = 1'b1;
               off_in   = cmp_off_ff + 1'b1;
               pend_in  = 1'b0;
            end else if (more) begin
               rd_en      = 1'b1;
               rd_addr    = ring_pos(head_ff, off_ff);
               pend_in    = 1'b1;
               cmp_off_in = off_ff;
               off_in     = off_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         CMD_SHIFT: begin
            // Move each later entry one place toward the front.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = ring_pos(head_ff, cmp_off_ff - 1'b1);
               wr_data = rd_data;
            end
            if (more) begin
               rd_en      = 1'b1;
               rd_addr    = ring_pos(head_ff, off_ff);
               pend_in    = 1'b1;
               cmp_off_in = off_ff;
               off_in     = off_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         CMD_RD_FRONT: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
         end
         CMD_RD_BACK: begin
            rd_en    = 1'b1;
            rd_addr  = ring_pos(head_ff, count_ff - 1'b1);
            front_in = rd_data;
         end
         CMD_CAP_BACK: begin
            back_in = rd_data;
         end
         CMD_OUTPUT: begin
            rsp_valid_in    = 1'b1;
            rsp_status_in   = status_ff;
            rsp_found_in    = found_ff;
            rsp_is_empty_in = is_empty;
            rsp_count_in    = count_ff;
            rsp_front_in    = is_empty ? '0 : front_ff;
            rsp_back_in     = is_empty ? '0 : back_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      val_ff          <= val_in;
      front_ff        <= front_in;
      back_ff         <= back_in;
      off_ff          <= off_in;
      cmp_off_ff      <= cmp_off_in;
      found_ff        <= found_in;
      status_ff       <= status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_is_empty_ff <= rsp_is_empty_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_front_ff    <= rsp_front_in;
      rsp_back_ff     <= rsp_back_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;

endmodule

// File: design/dbe_ctrl.sv
// Controller state machine of the queue engine.
`timescale 1ns / 1ps

module dbe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dbe_pkg::dp_stat_type stat,
   output dbe_pkg::cmd_type     cmd
);

   import dbe_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Next state and command.
   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.op)
               FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                  if (stat.is_full) begin
                     cmd = CMD_FAIL_FULL;
                  end else if (stat.op == FUNC_PUSH_FRONT) begin
                     cmd = CMD_PUSH_FRONT;
                  end else begin
                     cmd = CMD_PUSH_BACK;
                  end
                  state_in = ST_DONE;
               end
               FUNC_POP_FRONT, FUNC_POP_BACK: begin
                  if (stat.is_empty) begin
                     cmd      = CMD_FAIL_EMPTY;
                     state_in = ST_DONE;
                  end else begin
                     cmd      = (stat.op == FUNC_POP_FRONT) ? CMD_POP_FRONT : CMD_POP_BACK;
                     state_in = ST_REF_FRONT;
                  end
               end
               FUNC_CONTAINS, FUNC_REMOVE: begin
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCAN: begin
            // Search from the front, one entry per cycle.
            if (stat.scan_hit) begin
               cmd      = CMD_SCAN;
               state_in = (stat.op == FUNC_REMOVE) ? ST_SHIFT : ST_DONE;
            end else if (stat.sweep_done) begin
               cmd      = (stat.op == FUNC_REMOVE) ? CMD_FAIL_MISS : CMD_NONE;
               state_in = ST_DONE;
            end else begin
               cmd = CMD_SCAN;
            end
         end
         ST_SHIFT: begin
            // Close the gap, then drop the last entry.
            if (stat.sweep_done) begin
               cmd      = CMD_SHRINK;
               state_in = ST_REF_FRONT;
            end else begin
               cmd = CMD_SHIFT;
            end
         end
         ST_REF_FRONT: begin
            if (stat.is_empty) begin
               state_in = ST_DONE;
            end else begin
               cmd      = CMD_RD_FRONT;
               state_in = ST_REF_BACK;
            end
         end
         ST_REF_BACK: begin
            cmd      = CMD_RD_BACK;
            state_in = ST_REF_CAP;
         end
         ST_REF_CAP: begin
            cmd      = CMD_CAP_BACK;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Wait for the result register to be free.
            if (stat.out_free) begin
               cmd      = CMD_OUTPUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/deque_bag_engine_unit.sv
// Top level of the double-ended queue engine with search and remove.
//
// One item enters on the req_ channel (func and item_value) and produces
// exactly one item on the rsp_ channel: status, found flag, empty flag,
// count, and the front and back values after the operation (0 when empty).
// An item is taken when valid is high and stall is low; items are handled
// one at a time, and req_stall stays high from acceptance until the result
// has been moved into the output register.
// Pushes and refused operations go straight to the final state; pops, and a
// remove that finds its value, then read the new front and back values from
// the entry store unless the queue is now empty. The entry store has one
// read port, so the search and the gap-closing shift each go through the
// stored entries at one entry per cycle; that sets the rate for contains and
// remove.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver only holds the following item in the
// controller's final state until the register is taken.
// Synchronous reset empties the queue at once; no clearing pass is needed.
`timescale 1ns / 1ps

module deque_bag_engine_unit #(
   parameter int DEPTH       = dbe_pkg::DEFAULT_DEPTH,
   parameter int VALUE_WIDTH = dbe_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_func,
   input  logic signed [VALUE_WIDTH-1:0]     req_item_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_found,
   output logic                              rsp_is_empty,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_count,
   output logic signed [VALUE_WIDTH-1:0]     rsp_front_value,
   output logic signed [VALUE_WIDTH-1:0]     rsp_back_value
);

   import dbe_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;

   // Sequencing of each item.
   dbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage, pointers and result register.
   dbe_datapath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_count       (rsp_count),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value)
   );

endmodule
